// ===== rtl/core/rmhm_pkg.sv =====
`timescale 1ns / 1ps

package rmhm_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_MARK  = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  localparam logic [1:0] OUT_MATCHED  = 2'd0;
  localparam logic [1:0] OUT_NO_CAND  = 2'd1;
  localparam logic [1:0] OUT_REJECTED = 2'd2;
  localparam logic [1:0] OUT_EMPTY    = 2'd3;

  localparam logic CFG_RATIO  = 1'b0;
  localparam logic CFG_RADIUS = 1'b1;

  localparam logic [7:0]  RATIO_RESET  = 8'd179;
  localparam logic [31:0] RADIUS_RESET = 32'd640000;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input transaction accepted this cycle
    logic scan_rd;   // read table entry at the scan address
    logic load_out;  // capture the query result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } sts_t;

endpackage

// ===== rtl/core/rmhm_ctrl.sv =====
`timescale 1ns / 1ps

module rmhm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_req_type,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  rmhm_pkg::sts_t    sts,
  output rmhm_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd.take      = 1'b0;
    cmd.scan_rd   = 1'b0;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_req_type == rmhm_pkg::REQ_QUERY) begin
            state_nxt = sts.count_zero ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/rmhm_dp.sv =====
`timescale 1ns / 1ps

module rmhm_dp #(
  parameter int MAX_POINTS = 512,
  parameter int DESC_WORDS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rmhm_pkg::cmd_t    cmd,
  output rmhm_pkg::sts_t    sts,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        in_req_type,
  input  logic [15:0]       in_pos_x,
  input  logic [15:0]       in_pos_y,
  input  logic [63:0]       in_desc_word0,
  input  logic [63:0]       in_desc_word1,
  input  logic [63:0]       in_desc_word2,
  input  logic [63:0]       in_desc_word3,
  input  logic [8:0]        in_point_index,
  output logic [1:0]        out_outcome,
  output logic [8:0]        out_match_index,
  output logic [8:0]        out_best_distance
);

  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  // only four descriptor words have input ports; words past the fourth are not stored and never add distance
  localparam int USED_WORDS = (DESC_WORDS < 4) ? DESC_WORDS : 4;
  localparam int DESC_W     = USED_WORDS * 64;
  localparam int ENT_W      = DESC_W + 32;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int j = 0; j < 8; j++) begin
      n = n + 4'(v[j]);
    end
    return n;
  endfunction

  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int k = 0; k < 8; k++) begin
      n = n + 7'(pop8(v[k*8 +: 8]));
    end
    return n;
  endfunction

  // table memories
  logic [ENT_W-1:0] ent_mem  [MAX_POINTS];
  logic             flag_mem [MAX_POINTS];

  logic [CNT_W-1:0]  cnt_r;
  logic [7:0]        ratio_r;
  logic [31:0]       radius_r;
  logic [15:0]       qx_r, qy_r;
  logic [DESC_W-1:0] qdesc_r;
  logic [IDX_W-1:0]  scan_addr_r;

  // read stage
  logic [ENT_W-1:0]  rd_ent_r;
  logic              rd_flag_r, rd_v_r;
  logic [IDX_W-1:0]  rd_idx_r;
  // stage 1: abs differences, per-word popcounts
  logic [15:0]       dx_r, dy_r;
  logic [6:0]        pc_r [USED_WORDS];
  logic              s1_flag_r, s1_v_r;
  logic [IDX_W-1:0]  s1_idx_r;
  // stage 2: squares, Hamming distance
  logic [31:0]       dx2_r, dy2_r;
  logic [8:0]        hd2_r;
  logic              s2_flag_r, s2_v_r;
  logic [IDX_W-1:0]  s2_idx_r;
  // stage 3: radius test
  logic              s3_cand_r, s3_v_r;
  logic [8:0]        hd3_r;
  logic [IDX_W-1:0]  s3_idx_r;
  // running two-best
  logic [1:0]        cands_r, cands_nxt;
  logic [8:0]        best_r, best_nxt, second_r, second_nxt;
  logic [IDX_W-1:0]  best_i_r, best_i_nxt;

  logic [1:0]        outcome_r, outcome_nxt;
  logic [8:0]        match_r, match_nxt, dist_r, dist_nxt;

  logic [255:0]      in_desc;
  logic              take_load, take_mark, take_query, take_clear;
  logic              flag_we, flag_wd;
  logic [IDX_W-1:0]  flag_addr;
  logic [15:0]       ent_x, ent_y, dx, dy;
  logic [8:0]        hd_sum;
  logic [32:0]       d2;
  logic [16:0]       best_sh, ratio_prod;

  assign in_desc    = {in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0};
  assign take_clear = cmd.take && (in_req_type == rmhm_pkg::REQ_CLEAR);
  assign take_load  = cmd.take && (in_req_type == rmhm_pkg::REQ_LOAD)
                      && (cnt_r < CNT_W'(MAX_POINTS));
  assign take_mark  = cmd.take && (in_req_type == rmhm_pkg::REQ_MARK)
                      && (32'(in_point_index) < 32'(cnt_r));
  assign take_query = cmd.take && (in_req_type == rmhm_pkg::REQ_QUERY);

  assign flag_we   = take_load || take_mark;
  assign flag_wd   = take_mark;
  assign flag_addr = take_mark ? IDX_W'(in_point_index) : IDX_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (take_load) begin
      ent_mem[IDX_W'(cnt_r)] <= {in_pos_y, in_pos_x, in_desc[DESC_W-1:0]};
    end
    if (cmd.scan_rd) begin
      rd_ent_r <= ent_mem[scan_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_addr] <= flag_wd;
    end
    if (cmd.scan_rd) begin
      rd_flag_r <= flag_mem[scan_addr_r];
      rd_idx_r  <= scan_addr_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ratio_r     <= rmhm_pkg::RATIO_RESET;
      radius_r    <= rmhm_pkg::RADIUS_RESET;
      scan_addr_r <= '0;
      rd_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      cands_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rmhm_pkg::CFG_RATIO:  ratio_r  <= cfg_data[7:0];
          rmhm_pkg::CFG_RADIUS: radius_r <= cfg_data;
          default: ;
        endcase
      end
      if (take_clear) begin
        cnt_r <= '0;
      end else if (take_load) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (take_query) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      rd_v_r  <= cmd.scan_rd;
      s1_v_r  <= rd_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      cands_r <= take_query ? 2'd0 : cands_nxt;
    end
  end

  // query operands
  always_ff @(posedge clk) begin
    if (take_query) begin
      qx_r    <= in_pos_x;
      qy_r    <= in_pos_y;
      qdesc_r <= in_desc[DESC_W-1:0];
    end
  end

  assign ent_x = rd_ent_r[DESC_W +: 16];
  assign ent_y = rd_ent_r[DESC_W+16 +: 16];
  assign dx    = (ent_x >= qx_r) ? (ent_x - qx_r) : (qx_r - ent_x);
  assign dy    = (ent_y >= qy_r) ? (ent_y - qy_r) : (qy_r - ent_y);

  always_comb begin
    hd_sum = 9'd0;
    for (int w = 0; w < USED_WORDS; w++) begin
      hd_sum = hd_sum + 9'(pc_r[w]);
    end
  end

  assign d2 = 33'(dx2_r) + 33'(dy2_r);

  always_ff @(posedge clk) begin
    dx_r      <= dx;
    dy_r      <= dy;
    for (int w = 0; w < USED_WORDS; w++) begin
      pc_r[w] <= pop64(rd_ent_r[w*64 +: 64] ^ qdesc_r[w*64 +: 64]);
    end
    s1_flag_r <= rd_flag_r;
    s1_idx_r  <= rd_idx_r;

    dx2_r     <= dx_r * dx_r;
    dy2_r     <= dy_r * dy_r;
    hd2_r     <= hd_sum;
    s2_flag_r <= s1_flag_r;
    s2_idx_r  <= s1_idx_r;

    s3_cand_r <= s2_v_r && !s2_flag_r && (d2 <= 33'(radius_r));
    hd3_r     <= hd2_r;
    s3_idx_r  <= s2_idx_r;
  end

  // two-best tracking, ties keep the earlier index
  always_comb begin
    cands_nxt  = cands_r;
    best_nxt   = best_r;
    second_nxt = second_r;
    best_i_nxt = best_i_r;
    if (s3_v_r && s3_cand_r) begin
      if (cands_r == 2'd0) begin
        best_nxt   = hd3_r;
        best_i_nxt = s3_idx_r;
      end else if (hd3_r < best_r) begin
        second_nxt = best_r;
        best_nxt   = hd3_r;
        best_i_nxt = s3_idx_r;
      end else if (cands_r == 2'd1 || hd3_r < second_r) begin
        second_nxt = hd3_r;
      end
      if (cands_r != 2'd2) begin
        cands_nxt = cands_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r   <= best_nxt;
    second_r <= second_nxt;
    best_i_r <= best_i_nxt;
  end

  assign best_sh    = {best_r, 8'd0};
  assign ratio_prod = 17'(ratio_r) * 17'(second_r);

  always_comb begin
    outcome_nxt = rmhm_pkg::OUT_EMPTY;
    match_nxt   = 9'd0;
    dist_nxt    = 9'd0;
    if (cnt_r == '0) begin
      outcome_nxt = rmhm_pkg::OUT_EMPTY;
    end else if (cands_r == 2'd0) begin
      outcome_nxt = rmhm_pkg::OUT_NO_CAND;
    end else if (cands_r == 2'd1 || best_sh < ratio_prod) begin
      outcome_nxt = rmhm_pkg::OUT_MATCHED;
      match_nxt   = 9'(best_i_r);
      dist_nxt    = best_r;
    end else begin
      outcome_nxt = rmhm_pkg::OUT_REJECTED;
      dist_nxt    = best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      outcome_r <= outcome_nxt;
      match_r   <= match_nxt;
      dist_r    <= dist_nxt;
    end
  end

  assign out_outcome       = outcome_r;
  assign out_match_index   = match_r;
  assign out_best_distance = dist_r;

  assign sts.count_zero = (cnt_r == '0);
  assign sts.scan_last  = (CNT_W'(scan_addr_r) == (cnt_r - CNT_W'(1)));
  assign sts.pipe_busy  = rd_v_r || s1_v_r || s2_v_r || s3_v_r;

endmodule

// ===== rtl/core/radius_masked_hamming_matcher.sv =====
`timescale 1ns / 1ps

// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_index, cfg_data (ratio_q8, search_radius_sq)
// in       in   in_valid/in_ready    req_type, pos_x/y, desc_word0..3, point_index
// out      out  out_valid/out_ready  outcome, match_index, best_distance (queries only)
//
// Clear, load and mark take effect on the clock edge that accepts them. A query
// streams the table through the read/abs/square/radius pipeline at one entry per
// cycle; an empty table skips the scan. The single table read port sets that rate.
// Reset (sync, active low) empties the table and restores the config registers.
// A finished result waits in the output register; the next transaction is taken
// meanwhile, a following query holds in its last cycle until the result is taken.

module radius_masked_hamming_matcher #(
  parameter int MAX_POINTS = 512,
  parameter int DESC_WORDS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [63:0] in_desc_word0,
  input  logic [63:0] in_desc_word1,
  input  logic [63:0] in_desc_word2,
  input  logic [63:0] in_desc_word3,
  input  logic [8:0]  in_point_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [8:0]  out_match_index,
  output logic [8:0]  out_best_distance
);

  rmhm_pkg::cmd_t cmd;
  rmhm_pkg::sts_t sts;

  rmhm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  rmhm_dp #(
    .MAX_POINTS (MAX_POINTS),
    .DESC_WORDS (DESC_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_req_type       (in_req_type),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_desc_word0     (in_desc_word0),
    .in_desc_word1     (in_desc_word1),
    .in_desc_word2     (in_desc_word2),
    .in_desc_word3     (in_desc_word3),
    .in_point_index    (in_point_index),
    .out_outcome       (out_outcome),
    .out_match_index   (out_match_index),
    .out_best_distance (out_best_distance)
  );

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before transaction completed");

  // scans only run over a non-empty table
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> !sts.count_zero)
    else $error("table scan on empty table");

  // a new transaction is only taken with the pipeline drained
  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pipe_busy)
    else $error("input ready while scan pipeline busy");

  // empty or no-candidate outcomes carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == rmhm_pkg::OUT_EMPTY ||
                   out_outcome == rmhm_pkg::OUT_NO_CAND))
      |-> (out_match_index == 9'd0 && out_best_distance == 9'd0))
    else $error("nonzero payload on unmatched outcome");

endmodule
